### hw/rtl/assert_macros.svh
// assertion helper macros for the rtl in this folder
// depends on nothing; the using module must provide clk and rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside of reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/i2c_asr_pkg.sv
// shared types and constants for the i2c adc sample reader
// no dependencies
package i2c_asr_pkg;

  // commands carried by an input item
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_CHECK = 2'd3;

  // configuration register indexes
  localparam logic REG_DEVICE_ADDRESS   = 1'b0;
  localparam logic REG_EXPECTED_SETTING = 1'b1;

  // configuration reset values
  localparam logic [6:0] DEVICE_ADDRESS_RST   = 7'd104;
  localparam logic [4:0] EXPECTED_SETTING_RST = 5'd28;

  // bus sequencer phase codes
  localparam logic [4:0] PH_IDLE      = 5'd0;
  localparam logic [4:0] PH_START_LOW = 5'd1;
  localparam logic [4:0] PH_TX_DATA   = 5'd2;
  localparam logic [4:0] PH_TX_HIGH   = 5'd3;
  localparam logic [4:0] PH_TX_LOW    = 5'd4;
  localparam logic [4:0] PH_AW_REL    = 5'd5;
  localparam logic [4:0] PH_AW_HIGH   = 5'd6;
  localparam logic [4:0] PH_AW_LOW    = 5'd7;
  localparam logic [4:0] PH_RX_REL    = 5'd8;
  localparam logic [4:0] PH_RX_HIGH   = 5'd9;
  localparam logic [4:0] PH_RX_LOW    = 5'd10;
  localparam logic [4:0] PH_MA_DATA   = 5'd11;
  localparam logic [4:0] PH_MA_HIGH   = 5'd12;
  localparam logic [4:0] PH_MA_LOW    = 5'd13;
  localparam logic [4:0] PH_SP_LOW    = 5'd14;
  localparam logic [4:0] PH_SP_HIGH   = 5'd15;
  localparam logic [4:0] PH_SP_END    = 5'd16;

  // bits per byte on the bus
  localparam logic [3:0] BYTE_BITS = 4'd8;

  // decode constants
  localparam logic [7:0] BYTE_ALL_ONES = 8'hFF;

  // one result item
  typedef struct packed {
    logic        scl;
    logic        sda;
    logic        busy;
    logic        done;
    logic [16:0] value;
    logic        fresh;
    logic        over;
    logic        mismatch;
  } res_t;

endpackage

### hw/rtl/i2c_adc_sample_reader_core.sv
// i2c master for an 18-bit delta-sigma adc, one bus tick per input item
// depends on i2c_asr_pkg and assert_macros.svh
//
// usage:
//   each input item (cmd, setting_byte, sda_in) is one bus tick. a nonzero cmd
//   given while idle starts a transaction: read sample, write config byte or
//   check config. commands given while busy are ignored.
//   each accepted item gives exactly one result item: the scl/sda drive levels
//   after the tick, busy, and on the stop tick done with the decoded sample or
//   the config mismatch flag.
//   an item's result is registered by the edge that takes it, in the output
//   register or, when it stalls, the skid entry. one item is taken per cycle
//   while in_stall is low, and the sequencer state updates in that same edge.
//   when out_stall is high the result register holds and a one-entry skid
//   register takes one more item; in_stall rises only while that skid entry
//   is full.
//   reset clears the sequencer to idle with both lines released, sets the
//   configuration registers to address 104 and expected setting 28, and
//   empties the output side. configuration must be written through cfg_write,
//   cfg_index and cfg_data while the block is idle, which is not enforced.
`include "assert_macros.svh"

module i2c_adc_sample_reader_core #(
  parameter int READ_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration port
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [7:0]  setting_byte,
  input  logic        sda_in,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scl_out,
  output logic        sda_out,
  output logic        busy_res,
  output logic        done_res,
  output logic [16:0] sample_value,
  output logic        sample_fresh,
  output logic        overload,
  output logic        setting_mismatch
);

  localparam int IDX_W = (READ_BYTES > 1) ? $clog2(READ_BYTES) : 1;
  localparam logic [2:0] LAST_IDX = 3'(READ_BYTES - 1);

  // configuration registers
  logic [6:0] device_address;
  logic [4:0] expected_setting;

  // sequencer state
  logic [4:0] phase, phase_next;
  logic [1:0] operation, operation_next;
  logic [3:0] bit_counter, bit_counter_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [2:0] byte_index, byte_index_next;
  logic [7:0] result_hold, result_hold_next;
  logic       scl_drive, scl_drive_next;
  logic       sda_drive, sda_drive_next;

  // received bytes, written once per byte
  logic [7:0] read_bytes [READ_BYTES];
  logic       rb_write;

  // output register and skid stage
  i2c_asr_pkg::res_t out_res, skid_res, res;
  logic              skid_valid;

  logic in_accept;
  logic out_accept;
  logic [3:0] bit_counter_inc;
  logic [2:0] byte_index_inc;
  logic [7:0] b1, b2, b3, cfg_byte;

  assign in_stall   = skid_valid;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  assign bit_counter_inc = bit_counter + 4'd1;
  assign byte_index_inc  = byte_index + 3'd1;

  assign b1       = read_bytes[0];
  assign b2       = read_bytes[1];
  assign b3       = read_bytes[2];
  assign cfg_byte = read_bytes[LAST_IDX[IDX_W-1:0]];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address   <= i2c_asr_pkg::DEVICE_ADDRESS_RST;
      expected_setting <= i2c_asr_pkg::EXPECTED_SETTING_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        i2c_asr_pkg::REG_DEVICE_ADDRESS:   device_address   <= cfg_data;
        i2c_asr_pkg::REG_EXPECTED_SETTING: expected_setting <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // bus sequencer next state and result
  always_comb begin
    phase_next       = phase;
    operation_next   = operation;
    bit_counter_next = bit_counter;
    shift_byte_next  = shift_byte;
    byte_index_next  = byte_index;
    result_hold_next = result_hold;
    scl_drive_next   = scl_drive;
    sda_drive_next   = sda_drive;
    rb_write         = 1'b0;
    res              = '0;

    case (phase)
      i2c_asr_pkg::PH_IDLE: begin
        scl_drive_next = 1'b1;
        sda_drive_next = 1'b1;
        if (cmd != i2c_asr_pkg::CMD_TICK) begin
          operation_next   = cmd;
          result_hold_next = setting_byte;
          sda_drive_next   = 1'b0;
          phase_next       = i2c_asr_pkg::PH_START_LOW;
        end
      end
      i2c_asr_pkg::PH_START_LOW: begin
        scl_drive_next   = 1'b0;
        shift_byte_next  = {device_address, (operation != i2c_asr_pkg::CMD_WRITE)};
        bit_counter_next = '0;
        byte_index_next  = '0;
        phase_next       = i2c_asr_pkg::PH_TX_DATA;
      end
      i2c_asr_pkg::PH_TX_DATA: begin
        sda_drive_next = shift_byte[7];
        phase_next     = i2c_asr_pkg::PH_TX_HIGH;
      end
      i2c_asr_pkg::PH_TX_HIGH: begin
        scl_drive_next = 1'b1;
        phase_next     = i2c_asr_pkg::PH_TX_LOW;
      end
      i2c_asr_pkg::PH_TX_LOW: begin
        scl_drive_next   = 1'b0;
        shift_byte_next  = {shift_byte[6:0], 1'b0};
        bit_counter_next = bit_counter_inc;
        phase_next       = (bit_counter_inc >= i2c_asr_pkg::BYTE_BITS) ?
                           i2c_asr_pkg::PH_AW_REL : i2c_asr_pkg::PH_TX_DATA;
      end
      i2c_asr_pkg::PH_AW_REL: begin
        sda_drive_next = 1'b1;
        phase_next     = i2c_asr_pkg::PH_AW_HIGH;
      end
      i2c_asr_pkg::PH_AW_HIGH: begin
        scl_drive_next = 1'b1;
        phase_next     = i2c_asr_pkg::PH_AW_LOW;
      end
      i2c_asr_pkg::PH_AW_LOW: begin
        // slave ack is not checked
        scl_drive_next   = 1'b0;
        bit_counter_next = '0;
        if (operation == i2c_asr_pkg::CMD_WRITE) begin
          if (byte_index == 3'd0) begin
            shift_byte_next = result_hold;
            byte_index_next = 3'd1;
            phase_next      = i2c_asr_pkg::PH_TX_DATA;
          end else begin
            phase_next = i2c_asr_pkg::PH_SP_LOW;
          end
        end else begin
          byte_index_next = '0;
          phase_next      = i2c_asr_pkg::PH_RX_REL;
        end
      end
      i2c_asr_pkg::PH_RX_REL: begin
        sda_drive_next   = 1'b1;
        bit_counter_next = '0;
        shift_byte_next  = '0;
        phase_next       = i2c_asr_pkg::PH_RX_HIGH;
      end
      i2c_asr_pkg::PH_RX_HIGH: begin
        scl_drive_next  = 1'b1;
        shift_byte_next = {shift_byte[6:0], sda_in};
        phase_next      = i2c_asr_pkg::PH_RX_LOW;
      end
      i2c_asr_pkg::PH_RX_LOW: begin
        scl_drive_next   = 1'b0;
        bit_counter_next = bit_counter_inc;
        if (bit_counter_inc >= i2c_asr_pkg::BYTE_BITS) begin
          rb_write   = 1'b1;
          phase_next = i2c_asr_pkg::PH_MA_DATA;
        end else begin
          phase_next = i2c_asr_pkg::PH_RX_HIGH;
        end
      end
      i2c_asr_pkg::PH_MA_DATA: begin
        // ack every byte but nack the last one
        sda_drive_next = (byte_index >= LAST_IDX);
        phase_next     = i2c_asr_pkg::PH_MA_HIGH;
      end
      i2c_asr_pkg::PH_MA_HIGH: begin
        scl_drive_next = 1'b1;
        phase_next     = i2c_asr_pkg::PH_MA_LOW;
      end
      i2c_asr_pkg::PH_MA_LOW: begin
        scl_drive_next  = 1'b0;
        byte_index_next = byte_index_inc;
        phase_next      = (byte_index_inc > LAST_IDX) ?
                          i2c_asr_pkg::PH_SP_LOW : i2c_asr_pkg::PH_RX_REL;
      end
      i2c_asr_pkg::PH_SP_LOW: begin
        sda_drive_next = 1'b0;
        phase_next     = i2c_asr_pkg::PH_SP_HIGH;
      end
      i2c_asr_pkg::PH_SP_HIGH: begin
        scl_drive_next = 1'b1;
        phase_next     = i2c_asr_pkg::PH_SP_END;
      end
      i2c_asr_pkg::PH_SP_END: begin
        sda_drive_next = 1'b1;
        phase_next     = i2c_asr_pkg::PH_IDLE;
        res.done       = 1'b1;
        if (operation == i2c_asr_pkg::CMD_READ) begin
          // ready bit set means no new conversion
          if (!cfg_byte[7]) begin
            res.fresh = 1'b1;
            if (b1 == i2c_asr_pkg::BYTE_ALL_ONES && b2 == i2c_asr_pkg::BYTE_ALL_ONES &&
                b3 == i2c_asr_pkg::BYTE_ALL_ONES) begin
              res.value = '0;
            end else if (b1[1]) begin
              res.over = 1'b1;
            end else begin
              res.value = {b1[0], b2, b3};
            end
          end
        end else if (operation == i2c_asr_pkg::CMD_CHECK) begin
          res.mismatch = (cfg_byte[4:0] != expected_setting);
        end
      end
      default: begin
        phase_next     = i2c_asr_pkg::PH_IDLE;
        scl_drive_next = 1'b1;
        sda_drive_next = 1'b1;
      end
    endcase

    res.scl  = scl_drive_next;
    res.sda  = sda_drive_next;
    res.busy = (phase_next != i2c_asr_pkg::PH_IDLE);
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= i2c_asr_pkg::PH_IDLE;
      operation   <= '0;
      bit_counter <= '0;
      shift_byte  <= '0;
      byte_index  <= '0;
      result_hold <= '0;
      scl_drive   <= 1'b1;
      sda_drive   <= 1'b1;
    end else if (in_accept) begin
      phase       <= phase_next;
      operation   <= operation_next;
      bit_counter <= bit_counter_next;
      shift_byte  <= shift_byte_next;
      byte_index  <= byte_index_next;
      result_hold <= result_hold_next;
      scl_drive   <= scl_drive_next;
      sda_drive   <= sda_drive_next;
    end
  end

  // received byte store
  always_ff @(posedge clk) begin
    if (in_accept && rb_write) begin
      read_bytes[byte_index[IDX_W-1:0]] <= shift_byte;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      if (!out_valid || out_accept) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_accept) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (!out_valid || out_accept) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end else if (out_accept && skid_valid) begin
      out_res <= skid_res;
    end
  end

  assign scl_out          = out_res.scl;
  assign sda_out          = out_res.sda;
  assign busy_res         = out_res.busy;
  assign done_res         = out_res.done;
  assign sample_value     = out_res.value;
  assign sample_fresh     = out_res.fresh;
  assign overload         = out_res.over;
  assign setting_mismatch = out_res.mismatch;

  // checks
  `ASSERT_CLK(a_skid_needs_out, skid_valid |-> out_valid, "skid full with empty output")
  `ASSERT_CLK(a_stop_to_idle,
    (in_accept && phase == i2c_asr_pkg::PH_SP_END) |=> (phase == i2c_asr_pkg::PH_IDLE),
    "no idle after stop")
  `ASSERT_CLK(a_done_not_busy, (out_valid && done_res) |-> !busy_res, "done while busy")
  `ASSERT_CLK(a_quiet_fields,
    (out_valid && !done_res) |->
      (sample_value == '0 && !sample_fresh && !overload && !setting_mismatch),
    "result fields set without done")
  `ASSERT_CLK(a_idle_stable, (!in_accept) |=> $stable(phase), "phase moved without an item")

endmodule

### verif/tb_i2c_adc_sample_reader_core.sv
// testbench for i2c_adc_sample_reader_core: drives bus ticks and compares every result item
// depends on i2c_asr_pkg and the core rtl; a scoreboard class predicts the line drive and
// decoded sample for each tick while an adc model answers the master's read slots
module tb_i2c_adc_sample_reader_core;

  localparam int READ_BYTES = 4;
  localparam int RANDOM_TICKS = 1000;

  // predicts the bus sequencer tick by tick and holds the line states still to come
  class adc_bus_scoreboard;
    logic [6:0] device_address;
    logic [4:0] expected_setting;
    logic [4:0] phase;
    logic [1:0] operation;
    logic [3:0] bit_count;
    logic [7:0] shift;
    logic [2:0] byte_index;
    logic [7:0] rx_byte [4];
    logic [7:0] held_setting;
    logic       scl;
    logic       sda;
    i2c_asr_pkg::res_t line_states[$];
    int         ticks;
    int         checked;
    int         failures;

    function new();
      device_address   = i2c_asr_pkg::DEVICE_ADDRESS_RST;
      expected_setting = i2c_asr_pkg::EXPECTED_SETTING_RST;
      phase            = i2c_asr_pkg::PH_IDLE;
      operation        = i2c_asr_pkg::CMD_TICK;
      bit_count        = '0;
      shift            = '0;
      byte_index       = '0;
      held_setting     = '0;
      scl              = 1'b1;
      sda              = 1'b1;
      ticks            = 0;
      checked          = 0;
      failures         = 0;
      foreach (rx_byte[i]) rx_byte[i] = '0;
    endfunction

    function void set_register(logic idx, logic [6:0] val);
      if (idx == i2c_asr_pkg::REG_DEVICE_ADDRESS) device_address = val;
      else expected_setting = val[4:0];
    endfunction

    function int waiting();
      return line_states.size();
    endfunction

    // advance the sequencer by one accepted item and queue the line state it gives
    function void take_tick(logic [1:0] c, logic [7:0] s, logic d);
      logic [2:0] last_idx;
      logic [7:0] cfg;
      i2c_asr_pkg::res_t r;
      last_idx = 3'(READ_BYTES - 1);
      r = '0;
      ticks++;
      case (phase)
        i2c_asr_pkg::PH_IDLE: begin
          scl = 1'b1;
          sda = 1'b1;
          if (c != i2c_asr_pkg::CMD_TICK) begin
            operation    = c;
            held_setting = s;
            sda          = 1'b0;
            phase        = i2c_asr_pkg::PH_START_LOW;
          end
        end
        i2c_asr_pkg::PH_START_LOW: begin
          scl        = 1'b0;
          shift      = {device_address, operation != i2c_asr_pkg::CMD_WRITE};
          bit_count  = '0;
          byte_index = '0;
          phase      = i2c_asr_pkg::PH_TX_DATA;
        end
        i2c_asr_pkg::PH_TX_DATA: begin
          sda   = shift[7];
          phase = i2c_asr_pkg::PH_TX_HIGH;
        end
        i2c_asr_pkg::PH_TX_HIGH: begin
          scl   = 1'b1;
          phase = i2c_asr_pkg::PH_TX_LOW;
        end
        i2c_asr_pkg::PH_TX_LOW: begin
          scl       = 1'b0;
          shift     = {shift[6:0], 1'b0};
          bit_count = bit_count + 4'd1;
          phase     = (bit_count >= i2c_asr_pkg::BYTE_BITS) ?
                      i2c_asr_pkg::PH_AW_REL : i2c_asr_pkg::PH_TX_DATA;
        end
        i2c_asr_pkg::PH_AW_REL: begin
          sda   = 1'b1;
          phase = i2c_asr_pkg::PH_AW_HIGH;
        end
        i2c_asr_pkg::PH_AW_HIGH: begin
          scl   = 1'b1;
          phase = i2c_asr_pkg::PH_AW_LOW;
        end
        i2c_asr_pkg::PH_AW_LOW: begin
          scl       = 1'b0;
          bit_count = '0;
          if (operation == i2c_asr_pkg::CMD_WRITE) begin
            // second ack of a write ends it, the first one sends the setting
            if (byte_index == 3'd0) begin
              shift      = held_setting;
              byte_index = 3'd1;
              phase      = i2c_asr_pkg::PH_TX_DATA;
            end else begin
              phase = i2c_asr_pkg::PH_SP_LOW;
            end
          end else begin
            byte_index = '0;
            phase      = i2c_asr_pkg::PH_RX_REL;
          end
        end
        i2c_asr_pkg::PH_RX_REL: begin
          sda       = 1'b1;
          bit_count = '0;
          shift     = '0;
          phase     = i2c_asr_pkg::PH_RX_HIGH;
        end
        i2c_asr_pkg::PH_RX_HIGH: begin
          scl   = 1'b1;
          shift = {shift[6:0], d};
          phase = i2c_asr_pkg::PH_RX_LOW;
        end
        i2c_asr_pkg::PH_RX_LOW: begin
          scl       = 1'b0;
          bit_count = bit_count + 4'd1;
          if (bit_count >= i2c_asr_pkg::BYTE_BITS) begin
            rx_byte[byte_index[1:0]] = shift;
            phase = i2c_asr_pkg::PH_MA_DATA;
          end else begin
            phase = i2c_asr_pkg::PH_RX_HIGH;
          end
        end
        i2c_asr_pkg::PH_MA_DATA: begin
          // nack only the last byte read
          sda   = (byte_index >= last_idx);
          phase = i2c_asr_pkg::PH_MA_HIGH;
        end
        i2c_asr_pkg::PH_MA_HIGH: begin
          scl   = 1'b1;
          phase = i2c_asr_pkg::PH_MA_LOW;
        end
        i2c_asr_pkg::PH_MA_LOW: begin
          scl        = 1'b0;
          byte_index = byte_index + 3'd1;
          phase      = (byte_index > last_idx) ?
                       i2c_asr_pkg::PH_SP_LOW : i2c_asr_pkg::PH_RX_REL;
        end
        i2c_asr_pkg::PH_SP_LOW: begin
          sda   = 1'b0;
          phase = i2c_asr_pkg::PH_SP_HIGH;
        end
        i2c_asr_pkg::PH_SP_HIGH: begin
          scl   = 1'b1;
          phase = i2c_asr_pkg::PH_SP_END;
        end
        i2c_asr_pkg::PH_SP_END: begin
          cfg    = rx_byte[last_idx[1:0]];
          sda    = 1'b1;
          r.done = 1'b1;
          phase  = i2c_asr_pkg::PH_IDLE;
          if (operation == i2c_asr_pkg::CMD_READ) begin
            // ready bit clear means a new conversion
            if (!cfg[7]) begin
              r.fresh = 1'b1;
              if (rx_byte[0] == i2c_asr_pkg::BYTE_ALL_ONES &&
                  rx_byte[1] == i2c_asr_pkg::BYTE_ALL_ONES &&
                  rx_byte[2] == i2c_asr_pkg::BYTE_ALL_ONES)
                r.value = '0;
              else if (rx_byte[0][1])
                r.over = 1'b1;
              else
                r.value = {rx_byte[0][0], rx_byte[1], rx_byte[2]};
            end
          end else if (operation == i2c_asr_pkg::CMD_CHECK) begin
            r.mismatch = (cfg[4:0] != expected_setting);
          end
        end
        default: begin
          phase = i2c_asr_pkg::PH_IDLE;
          scl   = 1'b1;
          sda   = 1'b1;
        end
      endcase
      r.scl  = scl;
      r.sda  = sda;
      r.busy = (phase != i2c_asr_pkg::PH_IDLE);
      line_states.push_back(r);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      failures++;
      if (failures <= 60)
        $display("mismatch at result %0d, %s: got %0h, expected %0h", checked, what, got, want);
    endtask

    // compare one accepted result with the oldest predicted line state
    task check_result(i2c_asr_pkg::res_t got);
      i2c_asr_pkg::res_t want;
      if (line_states.size() == 0) begin
        report("result with nothing pending", 32'(got), 0);
      end else begin
        want = line_states.pop_front();
        if (got.scl !== want.scl) report("scl_out", got.scl, want.scl);
        if (got.sda !== want.sda) report("sda_out", got.sda, want.sda);
        if (got.busy !== want.busy) report("busy_res", got.busy, want.busy);
        if (got.done !== want.done) report("done_res", got.done, want.done);
        if (got.value !== want.value) report("sample_value", got.value, want.value);
        if (got.fresh !== want.fresh) report("sample_fresh", got.fresh, want.fresh);
        if (got.over !== want.over) report("overload", got.over, want.over);
        if (got.mismatch !== want.mismatch)
          report("setting_mismatch", got.mismatch, want.mismatch);
      end
      checked++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic        cfg_index = i2c_asr_pkg::REG_DEVICE_ADDRESS;
  logic [6:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = i2c_asr_pkg::CMD_TICK;
  logic [7:0]  setting_byte = '0;
  logic        sda_in = 1'b1;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        scl_out;
  logic        sda_out;
  logic        busy_res;
  logic        done_res;
  logic [16:0] sample_value;
  logic        sample_fresh;
  logic        overload;
  logic        setting_mismatch;

  bit src_gaps = 1'b1;
  bit sink_gaps = 1'b1;
  int reads_run = 0;
  int writes_run = 0;
  int checks_run = 0;
  int reg_writes = 0;

  adc_bus_scoreboard board = new();

  i2c_adc_sample_reader_core #(.READ_BYTES(READ_BYTES)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .setting_byte(setting_byte), .sda_in(sda_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .scl_out(scl_out), .sda_out(sda_out), .busy_res(busy_res), .done_res(done_res),
    .sample_value(sample_value), .sample_fresh(sample_fresh), .overload(overload),
    .setting_mismatch(setting_mismatch)
  );

  always #5 clk = ~clk;

  // hard stop in case a handshake never completes
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // result side: random stall before each result, then take it
  initial begin
    int n;
    forever begin
      n = sink_gaps ? $urandom_range(0, 7) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // compare every result item taken
  always @(posedge clk) begin : watch_results
    i2c_asr_pkg::res_t seen;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen = {scl_out, sda_out, busy_res, done_res, sample_value, sample_fresh, overload,
              setting_mismatch};
      board.check_result(seen);
    end
  end

  // one bus tick: optional gap, then hold the item until it is taken
  task send_item(input logic [1:0] c, input logic [7:0] s, input logic d);
    int gap;
    gap = src_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    setting_byte <= s;
    sda_in       <= d;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.take_tick(c, s, d);
  endtask

  // one transaction; the adc answers read slots from adc_word, first byte on top
  task run_transaction(input logic [1:0] op, input logic [7:0] setting,
                       input logic [31:0] adc_word);
    logic [1:0] c;
    logic [7:0] s;
    logic       d;
    int         lead;
    int         pos;
    lead = $urandom_range(0, 2);
    repeat (lead) send_item(i2c_asr_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
    send_item(op, setting, 1'($urandom));
    while (board.phase != i2c_asr_pkg::PH_IDLE) begin
      // commands now and then while busy, which must be ignored
      c = ($urandom_range(0, 3) == 0) ? 2'($urandom) : i2c_asr_pkg::CMD_TICK;
      s = 8'($urandom);
      d = 1'($urandom);
      if (board.phase == i2c_asr_pkg::PH_RX_HIGH) begin
        pos = 31 - 8 * board.byte_index - board.bit_count;
        d = adc_word[pos];
      end
      send_item(c, s, d);
    end
    case (op)
      i2c_asr_pkg::CMD_READ:  reads_run++;
      i2c_asr_pkg::CMD_WRITE: writes_run++;
      default:                checks_run++;
    endcase
  endtask

  // let the block settle, then rewrite both registers
  task reconfigure(input logic [6:0] addr, input logic [4:0] want_setting);
    in_valid <= 1'b0;
    do @(posedge clk); while (board.waiting() != 0);
    repeat (2) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= i2c_asr_pkg::REG_DEVICE_ADDRESS;
    cfg_data  <= addr;
    @(posedge clk);
    board.set_register(i2c_asr_pkg::REG_DEVICE_ADDRESS, addr);
    cfg_index <= i2c_asr_pkg::REG_EXPECTED_SETTING;
    cfg_data  <= {2'b00, want_setting};
    @(posedge clk);
    board.set_register(i2c_asr_pkg::REG_EXPECTED_SETTING, {2'b00, want_setting});
    cfg_write <= 1'b0;
    reg_writes += 2;
  endtask

  // main sequence
  initial begin
    int         random_start;
    int         trans;
    int         kind;
    int         wait_cycles;
    logic [1:0] op;
    logic [7:0] cfg;
    logic [31:0] word;
    logic [6:0] addr;
    logic [4:0] want_setting;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed transactions with the reset configuration
    run_transaction(i2c_asr_pkg::CMD_READ,  8'h00, 32'h01FF_FF1C);
    run_transaction(i2c_asr_pkg::CMD_READ,  8'hFF, 32'h0000_001C);
    run_transaction(i2c_asr_pkg::CMD_READ,  8'h5A, 32'h55AA_559C);
    run_transaction(i2c_asr_pkg::CMD_READ,  8'hA5, 32'hFFFF_FF1C);
    run_transaction(i2c_asr_pkg::CMD_READ,  8'h3C, 32'hFE12_341C);
    run_transaction(i2c_asr_pkg::CMD_WRITE, 8'hFF, 32'h0000_0000);
    run_transaction(i2c_asr_pkg::CMD_WRITE, 8'h00, 32'hFFFF_FFFF);
    run_transaction(i2c_asr_pkg::CMD_CHECK, 8'h81, 32'h1234_561C);
    run_transaction(i2c_asr_pkg::CMD_CHECK, 8'h7E, 32'h1234_56E3);

    // random transactions, reconfigured every few, extremes first
    random_start = board.ticks;
    trans = 0;
    while (board.ticks - random_start < RANDOM_TICKS) begin
      if (trans % 4 == 0) begin
        case (trans / 4)
          0: begin addr = 7'h00; want_setting = 5'h1F; end
          1: begin addr = 7'h7F; want_setting = 5'h00; end
          default: begin addr = 7'($urandom); want_setting = 5'($urandom); end
        endcase
        reconfigure(addr, want_setting);
      end
      if ($urandom_range(0, 5) == 0) begin
        src_gaps  = $urandom_range(0, 1);
        sink_gaps = $urandom_range(0, 1);
      end
      case ($urandom_range(0, 3))
        0, 1: op = i2c_asr_pkg::CMD_READ;
        2: op = i2c_asr_pkg::CMD_WRITE;
        default: op = i2c_asr_pkg::CMD_CHECK;
      endcase
      // pick the kind of conversion the adc reports
      kind = $urandom_range(0, 9);
      word = $urandom;
      cfg = 8'($urandom);
      case (kind)
        0: cfg[7] = 1'b1;
        1: begin word[31:8] = 24'hFF_FFFF; cfg[7] = 1'b0; end
        2: begin word[25] = 1'b1; cfg[7] = 1'b0; end
        3: ;
        default: begin word[25] = 1'b0; cfg[7] = 1'b0; end
      endcase
      if (op == i2c_asr_pkg::CMD_CHECK && $urandom_range(0, 1) == 0)
        cfg[4:0] = board.expected_setting;
      word[31 - 8 * (READ_BYTES - 1) -: 8] = cfg;
      run_transaction(op, 8'($urandom), word);
      trans++;
    end

    // drain
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (board.waiting() != 0 && wait_cycles < 2000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (4) @(posedge clk);
    if (board.waiting() != 0) board.report("results never seen", board.waiting(), 0);

    $display("covered %0d sample reads, %0d setting writes, %0d setting checks, %0d reg writes",
             reads_run, writes_run, checks_run, reg_writes);
    $display("%0d bus ticks sent, %0d results compared, %0d mismatches",
             board.ticks, board.checked, board.failures);
    if (board.failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
